### sv/sdd_pkg.sv
// Package for the speed dip event detector.
// Holds the field widths, the sample period, the register indexes and reset values.
// Used by the channel interfaces and by the top level.
package sdd_pkg;

  localparam int unsigned SAMPLE_PERIOD = 3;
  localparam int unsigned PHASE_W = $clog2(SAMPLE_PERIOD + 1);

  localparam int unsigned VEL_W = 16;
  localparam int unsigned MAG_W = 15;
  localparam int unsigned SUM_W = 16;
  localparam int unsigned TOTAL_W = 8;
  localparam int unsigned EVENTS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic signed [VEL_W-1:0] velocity_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [EVENTS_W-1:0] events_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [PHASE_W-1:0] phase_t;

  localparam cfg_idx_t CFG_SINGLE_LOW = 2'd0;
  localparam cfg_idx_t CFG_DOUBLE_LOW = 2'd1;
  localparam cfg_idx_t CFG_UPPER_LIMIT = 2'd2;

  localparam cfg_data_t SINGLE_LOW_RST = 16'd110;
  localparam cfg_data_t DOUBLE_LOW_RST = 16'd170;
  localparam cfg_data_t UPPER_LIMIT_RST = 16'd400;

  localparam events_t EVENTS_NONE = 2'd0;
  localparam events_t EVENTS_ONE = 2'd1;
  localparam events_t EVENTS_TWO = 2'd2;

endpackage

### sv/sdd_if.sv
// Valid/ready channel interfaces for the speed dip event detector.
// Sample input, result output and configuration write channels.
// Depends on sdd_pkg.
interface sdd_in_if;
  import sdd_pkg::*;
  logic valid;
  logic ready;
  velocity_t velocity;
  modport source (output valid, output velocity, input ready);
  modport sink (input valid, input velocity, output ready);
endinterface

interface sdd_out_if;
  import sdd_pkg::*;
  logic valid;
  logic ready;
  events_t events;
  total_t event_total;
  logic sampled;
  modport source (output valid, output events, output event_total, output sampled,
                  input ready);
  modport sink (input valid, input events, input event_total, input sampled,
                output ready);
endinterface

interface sdd_cfg_if;
  import sdd_pkg::*;
  logic valid;
  logic ready;
  cfg_idx_t index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/speed_dip_event_detector_top.sv
// Top level of the speed dip event detector.
// Depends on sdd_pkg and the channel interfaces in sdd_if.sv.
//
//   channel  direction  payload                          ready
//   in_i     sink       velocity                         low while a result stalls
//   out_o    source     events, event_total, sampled     from the consumer
//   cfg_i    sink       index, data                      always high
//
// One sample is taken per cycle while the result register can take it; its result
// is registered in the output register and shown from the next cycle.
// The single result register sets this rate: a new sample is taken whenever
// that register is empty or is being read in the same cycle.
// Reset loads the threshold reset values and clears phase, last speed, drop sum, total and output valid.
module speed_dip_event_detector_top (
  input  logic clk_i,
  input  logic rst_ni,
  sdd_in_if.sink    in_i,
  sdd_out_if.source out_o,
  sdd_cfg_if.sink   cfg_i
);
  import sdd_pkg::*;

  cfg_data_t single_low_q, double_low_q, upper_limit_q;
  phase_t phase_q, phase_d;
  mag_t last_speed_q, last_speed_d;
  sum_t drop_sum_q, drop_sum_d;
  total_t total_q, total_d;

  logic out_valid_q;
  events_t events_q, events_d;
  total_t out_total_q;
  logic sampled_q, sampled_d;

  logic in_fire, out_fire;
  mag_t speed;
  logic [VEL_W-1:0] neg_vel;
  logic [SUM_W:0] sum_wide;

  assign out_fire = out_valid_q && out_o.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid = out_valid_q;
  assign out_o.events = events_q;
  assign out_o.event_total = out_total_q;
  assign out_o.sampled = sampled_q;

  always_comb begin
    neg_vel = ~in_i.velocity + 1'b1;
    if (in_i.velocity[VEL_W-1]) begin
      if (neg_vel[VEL_W-1]) begin
        speed = '1;
      end else begin
        speed = neg_vel[MAG_W-1:0];
      end
    end else begin
      speed = in_i.velocity[MAG_W-1:0];
    end

    sum_wide = {1'b0, drop_sum_q} + {{(SUM_W + 1 - MAG_W){1'b0}}, last_speed_q - speed};

    phase_d = phase_q + 1'b1;
    last_speed_d = last_speed_q;
    drop_sum_d = drop_sum_q;
    total_d = total_q;
    events_d = EVENTS_NONE;
    sampled_d = 1'b0;

    if (phase_q >= PHASE_W'(SAMPLE_PERIOD)) begin
      sampled_d = 1'b1;
      phase_d = PHASE_W'(1);
      last_speed_d = speed;
      if (speed < last_speed_q) begin
        drop_sum_d = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end else begin
        if (drop_sum_q > single_low_q && drop_sum_q < double_low_q) begin
          events_d = EVENTS_ONE;
        end else if (drop_sum_q >= double_low_q && drop_sum_q < upper_limit_q) begin
          events_d = EVENTS_TWO;
        end
        drop_sum_d = '0;
        total_d = total_q + {{(TOTAL_W - EVENTS_W){1'b0}}, events_d};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_low_q <= SINGLE_LOW_RST;
      double_low_q <= DOUBLE_LOW_RST;
      upper_limit_q <= UPPER_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SINGLE_LOW: single_low_q <= cfg_i.data;
        CFG_DOUBLE_LOW: double_low_q <= cfg_i.data;
        CFG_UPPER_LIMIT: upper_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      last_speed_q <= '0;
      drop_sum_q <= '0;
      total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        last_speed_q <= last_speed_d;
        drop_sum_q <= drop_sum_d;
        total_q <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      events_q <= events_d;
      out_total_q <= total_d;
      sampled_q <= sampled_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PHASE_W'(SAMPLE_PERIOD))
    else $error("Sample phase exceeded the sample period.");

  a_total_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(total_q))
    else $error("Event total changed without an accepted transaction.");

  a_unsampled_no_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !sampled_q |-> events_q == EVENTS_NONE)
    else $error("Events reported on a sample that was not evaluated.");

  a_out_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_total_q == total_q)
    else $error("Result total differs from the running total.");

  a_sum_cleared_on_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && sampled_d && !(speed < last_speed_q) |=> drop_sum_q == '0)
    else $error("Drop sum not cleared after classification.");

endmodule

### verif/dip_result_checker.sv
// Result checker for the speed dip event detector testbench.
// Watches the sample, result and configuration channels, predicts each result
// and compares it with what the block delivers. Depends on sdd_pkg and sdd_if.sv.
module dip_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdd_in_if           in_mon,
  sdd_out_if          out_mon,
  sdd_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdd_pkg::*;

  typedef struct packed {
    events_t events;
    total_t  event_total;
    logic    sampled;
  } dip_result_t;

  dip_result_t expected_q[$];

  phase_t      phase_cnt;
  logic [15:0] last_mag;
  sum_t        drop_sum;
  total_t      dip_total;
  cfg_data_t   single_low;
  cfg_data_t   double_low;
  cfg_data_t   upper_limit;

  function automatic logic [15:0] speed_magnitude(velocity_t v);
    logic [15:0] m;
    m = v[VEL_W-1] ? 16'(-v) : 16'(v);
    return (m > 16'd32767) ? 16'd32767 : m;
  endfunction

  function automatic dip_result_t track_speed_dip(velocity_t v);
    logic [15:0] mag;
    logic [16:0] sum_ext;
    dip_result_t r;
    mag = speed_magnitude(v);
    r = '0;
    if (phase_cnt >= SAMPLE_PERIOD) begin
      r.sampled = 1'b1;
      phase_cnt = '0;
      if (mag < last_mag) begin
        sum_ext = {1'b0, drop_sum} + {1'b0, 16'(last_mag - mag)};
        drop_sum = sum_ext[16] ? 16'hFFFF : sum_ext[15:0];
      end else begin
        if (drop_sum > single_low && drop_sum < double_low) begin
          r.events = EVENTS_ONE;
        end else if (drop_sum >= double_low && drop_sum < upper_limit) begin
          r.events = EVENTS_TWO;
        end else begin
          r.events = EVENTS_NONE;
        end
        drop_sum = '0;
        dip_total = dip_total + total_t'(r.events);
      end
      last_mag = mag;
    end
    phase_cnt = phase_cnt + 1'b1;
    r.event_total = dip_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dip_result_t exp_res;
    if (!rst_ni) begin
      phase_cnt = '0;
      last_mag = '0;
      drop_sum = '0;
      dip_total = '0;
      single_low = SINGLE_LOW_RST;
      double_low = DOUBLE_LOW_RST;
      upper_limit = UPPER_LIMIT_RST;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.index)
          CFG_SINGLE_LOW: begin
            single_low = cfg_mon.data;
          end
          CFG_DOUBLE_LOW: begin
            double_low = cfg_mon.data;
          end
          CFG_UPPER_LIMIT: begin
            upper_limit = cfg_mon.data;
          end
          default: begin
          end
        endcase
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_mon.events !== exp_res.events) begin
            $error("events mismatch: expected %0d, actual %0d",
                   exp_res.events, out_mon.events);
            fail_count_o = fail_count_o + 1;
          end
          if (out_mon.event_total !== exp_res.event_total) begin
            $error("event_total mismatch: expected %0d, actual %0d",
                   exp_res.event_total, out_mon.event_total);
            fail_count_o = fail_count_o + 1;
          end
          if (out_mon.sampled !== exp_res.sampled) begin
            $error("sampled mismatch: expected %0d, actual %0d",
                   exp_res.sampled, out_mon.sampled);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        expected_q.push_back(track_speed_dip(in_mon.velocity));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### verif/tb.sv
// Top of the speed dip event detector testbench: clock, reset, stimulus and verdict.
// Drives directed and random speed samples under several threshold settings.
// Depends on sdd_pkg, sdd_if.sv, the block and dip_result_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned fail_count;
  int unsigned pending;

  int          walk_mag;
  int          walk_scale;
  bit          in_burst;
  bit          out_burst;
  int unsigned ready_hold;

  sdd_in_if  in_ch ();
  sdd_out_if out_ch ();
  sdd_cfg_if cfg_ch ();

  speed_dip_event_detector_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  dip_result_checker result_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic velocity_t next_speed();
    int unsigned roll;
    int          delta;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      delta = (int'($urandom_range(0, 160)) - 120) * walk_scale;
      walk_mag = walk_mag + delta;
      if (walk_mag < 0) walk_mag = $urandom_range(1000, 32767);
      if (walk_mag > 32767) walk_mag = 32767;
      return $urandom_range(0, 1) ? velocity_t'(-walk_mag) : velocity_t'(walk_mag);
    end
    if (roll < 88) return velocity_t'($urandom);
    case ($urandom_range(0, 4))
      0: return velocity_t'(-32768);
      1: return velocity_t'(32767);
      2: return velocity_t'(0);
      3: return velocity_t'(-1);
      default: return velocity_t'(1);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) out_burst <= ~out_burst;
      if (!out_burst && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  task automatic send_speed(input velocity_t v);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : pick_gap();
    in_ch.valid <= 1'b1;
    in_ch.velocity <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.velocity <= velocity_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_thresholds(input cfg_data_t lo_one, input cfg_data_t lo_two,
                                  input cfg_data_t hi_lim);
    cfg_idx_t  idx[3];
    cfg_data_t val[3];
    idx = '{CFG_SINGLE_LOW, CFG_DOUBLE_LOW, CFG_UPPER_LIMIT};
    val = '{lo_one, lo_two, hi_lim};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= val[i];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input int scale);
    walk_scale = scale;
    for (int unsigned n = 0; n < count; n++) begin
      send_speed(next_speed());
    end
  endtask

  initial begin
    velocity_t directed[25];
    cfg_data_t lo_a;
    cfg_data_t lo_b;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.velocity = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SINGLE_LOW;
    cfg_ch.data = '0;
    ready_hold = 0;
    out_burst = 1'b0;
    in_burst = 1'b0;
    walk_mag = 16000;
    walk_scale = 1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Evaluated samples sit at positions 3, 6, 9 and so on; the rest are skipped.
    directed = '{-16'sd32768, 16'sd32767, 16'sd0,
                 -16'sd32768, -16'sd1, 16'sd1,
                 16'sd32597, -16'sd32768, 16'sd0,
                 -16'sd32597, 16'sd7, -16'sd7,
                 16'sd32197, 16'sd0, 16'sd32767,
                 16'sd32767, -16'sd2, 16'sd2,
                 -16'sd32656, 16'sd100, -16'sd100,
                 16'sd32656, 16'sd0, 16'sd0,
                 16'sd0};
    foreach (directed[i]) send_speed(directed[i]);
    walk_mag = 0;
    run_random(78, 1);

    drain_results();
    write_thresholds(16'd75, 16'd150, 16'd400);
    run_random(78, 1);

    drain_results();
    write_thresholds(16'd0, 16'd0, 16'd0);
    run_random(78, 1);

    drain_results();
    write_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(78, 64);

    drain_results();
    write_thresholds(16'd0, 16'hFFFF, 16'hFFFF);
    run_random(78, 16);

    drain_results();
    write_thresholds(16'd200, 16'd100, 16'd300);
    run_random(78, 1);

    drain_results();
    lo_a = cfg_data_t'($urandom_range(0, 300));
    lo_b = cfg_data_t'($urandom_range(0, 500));
    write_thresholds(lo_a, lo_b, cfg_data_t'($urandom_range(100, 700)));
    run_random(78, $urandom_range(1, 4));

    drain_results();
    write_thresholds(SINGLE_LOW_RST, DOUBLE_LOW_RST, UPPER_LIMIT_RST);
    run_random(78, 1);

    drain_results();
    if (fail_count == 0) begin
      $display("PASS speed_dip_event_detector_top");
    end else begin
      $display("FAIL speed_dip_event_detector_top");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL speed_dip_event_detector_top");
    $finish;
  end

endmodule
